// ===== sv/lcd_window_fill_command_generator_top_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef LCD_WINDOW_FILL_COMMAND_GENERATOR_TOP_DEFINES_SVH
`define LCD_WINDOW_FILL_COMMAND_GENERATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LWFC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lwfc assertion failed");
// next-cycle implication
`define LWFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lwfc assertion failed");
`else
`define LWFC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define LWFC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/lwfc_pkg.sv =====
package lwfc_pkg;

   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QAW    = $clog2(QDEPTH);
   localparam int unsigned QCW    = $clog2(QDEPTH + 1);

   // register indexes
   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [9:0] SCREEN_WIDTH_RESET  = 10'd240;
   localparam logic [9:0] SCREEN_HEIGHT_RESET = 10'd320;
   localparam logic [15:0] CACHE_RESET        = 16'hFFFF;

   // request kinds
   localparam logic REQ_FILL  = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   // result word kinds
   localparam logic [1:0] KIND_CMD  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_RUN  = 2'd2;

   // controller commands
   localparam logic [7:0] CMD_COL_SET   = 8'h2A;
   localparam logic [7:0] CMD_ROW_SET   = 8'h2B;
   localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

   // sequencer steps
   localparam logic [3:0] ST_BEGIN    = 4'd0;
   localparam logic [3:0] ST_COL_CMD  = 4'd1;
   localparam logic [3:0] ST_COL_SHI  = 4'd2;
   localparam logic [3:0] ST_COL_SLO  = 4'd3;
   localparam logic [3:0] ST_COL_EHI  = 4'd4;
   localparam logic [3:0] ST_COL_ELO  = 4'd5;
   localparam logic [3:0] ST_ROW_CMD  = 4'd6;
   localparam logic [3:0] ST_ROW_SHI  = 4'd7;
   localparam logic [3:0] ST_ROW_SLO  = 4'd8;
   localparam logic [3:0] ST_ROW_EHI  = 4'd9;
   localparam logic [3:0] ST_ROW_ELO  = 4'd10;
   localparam logic [3:0] ST_MEM      = 4'd11;
   localparam logic [3:0] ST_RUN      = 4'd12;

   // classified request after clipping
   typedef struct packed {
      logic [15:0] x_start;
      logic [15:0] x_end;
      logic [15:0] y_start;
      logic [15:0] y_end;
      logic [9:0]  w_len;
      logic [9:0]  h_len;
      logic [15:0] color;
   } stage_type;

   // queued work for the back end
   typedef struct packed {
      logic        col_send;
      logic        row_send;
      logic [15:0] x_start;
      logic [15:0] x_end;
      logic [15:0] y_start;
      logic [15:0] y_end;
      logic [15:0] color;
      logic [19:0] len;
   } desc_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// ===== sv/lwfc_req_if.sv =====
interface lwfc_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] origin_x;
   logic [15:0] origin_y;
   logic [15:0] rect_width;
   logic [15:0] rect_height;
   logic [15:0] fill_color;

   modport source (output valid, req_type, origin_x, origin_y, rect_width, rect_height,
                   fill_color, input ready);
   modport sink (input valid, req_type, origin_x, origin_y, rect_width, rect_height,
                 fill_color, output ready);
endinterface

// ===== sv/lwfc_rsp_if.sv =====
interface lwfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  item_kind;
   logic [7:0]  byte_value;
   logic [15:0] run_color;
   logic [19:0] run_length;
   logic        last_item;

   modport source (output valid, item_kind, byte_value, run_color, run_length, last_item,
                   input ready);
   modport sink (input valid, item_kind, byte_value, run_color, run_length, last_item,
                 output ready);
endinterface

// ===== sv/lwfc_csr_if.sv =====
interface lwfc_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [9:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/lwfc_front.sv =====
`include "lcd_window_fill_command_generator_top_defines.svh"

module lwfc_front (
   input  logic               clock,
   input  logic               reset,
   lwfc_req_if.sink           req,
   lwfc_csr_if.sink           csr,
   input  lwfc_pkg::qstat_type qstat,
   output logic               q_push,
   output lwfc_pkg::desc_type q_desc
);

   logic [9:0]  sw_ff, sw_in, sh_ff, sh_in;
   logic        s1_valid_ff, s1_valid_in;
   lwfc_pkg::stage_type s1_ff, s1_in;
   logic [15:0] ccs_ff, ccs_in, cce_ff, cce_in, crs_ff, crs_in, cre_ff, cre_in;

   logic        accept, drop, off, zero, clip_x, clip_y;
   logic [16:0] end_x, end_y;
   logic        col_send, row_send;

   assign csr.ready = 1'b1;

   always_comb begin
      sw_in = sw_ff;
      sh_in = sh_ff;
      if (csr.valid) begin
         unique case (csr.index)
            lwfc_pkg::CSR_SCREEN_WIDTH:  sw_in = csr.data;
            lwfc_pkg::CSR_SCREEN_HEIGHT: sh_in = csr.data;
            default: ;
         endcase
      end
   end

   // stage 1: off-screen test and clipping
   assign off  = (req.origin_x >= 16'(sw_ff)) || (req.origin_y >= 16'(sh_ff));
   assign zero = (req.rect_width == 16'd0) || (req.rect_height == 16'd0);
   assign drop = (req.req_type == lwfc_pkg::REQ_FILL) && (off || zero);

   assign end_x  = {1'b0, req.origin_x} + {1'b0, req.rect_width} - 17'd1;
   assign end_y  = {1'b0, req.origin_y} + {1'b0, req.rect_height} - 17'd1;
   assign clip_x = end_x >= 17'(sw_ff);
   assign clip_y = end_y >= 17'(sh_ff);

   assign q_push    = s1_valid_ff && !qstat.full;
   assign req.ready = !s1_valid_ff || !qstat.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      s1_in.x_start = req.origin_x;
      s1_in.y_start = req.origin_y;
      s1_in.color   = req.fill_color;
      if (req.req_type == lwfc_pkg::REQ_PIXEL) begin
         s1_in.x_end = req.origin_x + 16'd1;
         s1_in.y_end = req.origin_y + 16'd1;
         s1_in.w_len = 10'd1;
         s1_in.h_len = 10'd1;
      end else begin
         s1_in.x_end = clip_x ? 16'(sw_ff - 10'd1) : end_x[15:0];
         s1_in.y_end = clip_y ? 16'(sh_ff - 10'd1) : end_y[15:0];
         s1_in.w_len = clip_x ? sw_ff - req.origin_x[9:0] : req.rect_width[9:0];
         s1_in.h_len = clip_y ? sh_ff - req.origin_y[9:0] : req.rect_height[9:0];
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = !drop;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // stage 2: window cache compare and pixel count
   assign col_send = (s1_ff.x_start != ccs_ff) || (s1_ff.x_end != cce_ff);
   assign row_send = (s1_ff.y_start != crs_ff) || (s1_ff.y_end != cre_ff);

   always_comb begin
      q_desc.col_send = col_send;
      q_desc.row_send = row_send;
      q_desc.x_start  = s1_ff.x_start;
      q_desc.x_end    = s1_ff.x_end;
      q_desc.y_start  = s1_ff.y_start;
      q_desc.y_end    = s1_ff.y_end;
      q_desc.color    = s1_ff.color;
      q_desc.len      = s1_ff.w_len * s1_ff.h_len;
   end

   assign ccs_in = q_push ? s1_ff.x_start : ccs_ff;
   assign cce_in = q_push ? s1_ff.x_end   : cce_ff;
   assign crs_in = q_push ? s1_ff.y_start : crs_ff;
   assign cre_in = q_push ? s1_ff.y_end   : cre_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff       <= lwfc_pkg::SCREEN_WIDTH_RESET;
         sh_ff       <= lwfc_pkg::SCREEN_HEIGHT_RESET;
         s1_valid_ff <= 1'b0;
         ccs_ff      <= lwfc_pkg::CACHE_RESET;
         cce_ff      <= lwfc_pkg::CACHE_RESET;
         crs_ff      <= lwfc_pkg::CACHE_RESET;
         cre_ff      <= lwfc_pkg::CACHE_RESET;
      end else begin
         sw_ff       <= sw_in;
         sh_ff       <= sh_in;
         s1_valid_ff <= s1_valid_in;
         ccs_ff      <= ccs_in;
         cce_ff      <= cce_in;
         crs_ff      <= crs_in;
         cre_ff      <= cre_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // a stalled request must not vanish from stage 1
   `LWFC_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && qstat.full, s1_valid_ff)

endmodule

// ===== sv/lwfc_queue.sv =====
`include "lcd_window_fill_command_generator_top_defines.svh"

module lwfc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lwfc_pkg::desc_type  push_desc,
   input  logic                pop,
   output lwfc_pkg::desc_type  head,
   output lwfc_pkg::qstat_type qstat
);

   lwfc_pkg::desc_type mem_ff [lwfc_pkg::QDEPTH];
   logic [lwfc_pkg::QAW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [lwfc_pkg::QCW-1:0] cnt_ff, cnt_in;

   assign qstat.full  = cnt_ff == lwfc_pkg::QCW'(lwfc_pkg::QDEPTH);
   assign qstat.empty = cnt_ff == '0;
   assign head        = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + lwfc_pkg::QAW'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + lwfc_pkg::QAW'(1) : rd_ptr_ff;

   always_comb begin
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + lwfc_pkg::QCW'(1);
         2'b01:   cnt_in = cnt_ff - lwfc_pkg::QCW'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   `LWFC_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= lwfc_pkg::QCW'(lwfc_pkg::QDEPTH))

endmodule

// ===== sv/lwfc_back.sv =====
`include "lcd_window_fill_command_generator_top_defines.svh"

module lwfc_back (
   input  logic                clock,
   input  logic                reset,
   input  lwfc_pkg::desc_type  head,
   input  lwfc_pkg::qstat_type qstat,
   output logic                pop,
   lwfc_rsp_if.source          rsp
);

   logic [3:0]  step_ff, step_in, start, cur, nxt;
   logic        load;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic [15:0] color_ff, color_in;
   logic [19:0] len_ff, len_in;
   logic        last_ff, last_in;

   assign start = head.col_send ? lwfc_pkg::ST_COL_CMD :
                  head.row_send ? lwfc_pkg::ST_ROW_CMD : lwfc_pkg::ST_MEM;
   assign cur   = (step_ff == lwfc_pkg::ST_BEGIN) ? start : step_ff;

   assign load = !qstat.empty && (!rsp_valid_ff || rsp.ready);
   assign pop  = load && (cur == lwfc_pkg::ST_RUN);

   always_comb begin
      unique case (cur)
         lwfc_pkg::ST_COL_ELO: nxt = head.row_send ? lwfc_pkg::ST_ROW_CMD : lwfc_pkg::ST_MEM;
         lwfc_pkg::ST_RUN:     nxt = lwfc_pkg::ST_BEGIN;
         default:              nxt = cur + 4'd1;
      endcase
   end

   assign step_in = load ? nxt : step_ff;

   always_comb begin
      kind_in  = lwfc_pkg::KIND_DATA;
      byte_in  = 8'd0;
      color_in = 16'd0;
      len_in   = 20'd0;
      last_in  = 1'b0;
      unique case (cur)
         lwfc_pkg::ST_COL_CMD: begin
            kind_in = lwfc_pkg::KIND_CMD;
            byte_in = lwfc_pkg::CMD_COL_SET;
         end
         lwfc_pkg::ST_COL_SHI: byte_in = head.x_start[15:8];
         lwfc_pkg::ST_COL_SLO: byte_in = head.x_start[7:0];
         lwfc_pkg::ST_COL_EHI: byte_in = head.x_end[15:8];
         lwfc_pkg::ST_COL_ELO: byte_in = head.x_end[7:0];
         lwfc_pkg::ST_ROW_CMD: begin
            kind_in = lwfc_pkg::KIND_CMD;
            byte_in = lwfc_pkg::CMD_ROW_SET;
         end
         lwfc_pkg::ST_ROW_SHI: byte_in = head.y_start[15:8];
         lwfc_pkg::ST_ROW_SLO: byte_in = head.y_start[7:0];
         lwfc_pkg::ST_ROW_EHI: byte_in = head.y_end[15:8];
         lwfc_pkg::ST_ROW_ELO: byte_in = head.y_end[7:0];
         lwfc_pkg::ST_MEM: begin
            kind_in = lwfc_pkg::KIND_CMD;
            byte_in = lwfc_pkg::CMD_MEM_WRITE;
         end
         lwfc_pkg::ST_RUN: begin
            kind_in  = lwfc_pkg::KIND_RUN;
            color_in = head.color;
            len_in   = head.len;
            last_in  = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= lwfc_pkg::ST_BEGIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         byte_ff  <= byte_in;
         color_ff <= color_in;
         len_ff   <= len_in;
         last_ff  <= last_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.item_kind  = kind_ff;
   assign rsp.byte_value = byte_ff;
   assign rsp.run_color  = color_ff;
   assign rsp.run_length = len_ff;
   assign rsp.last_item  = last_ff;

   // the closing word of a request is always the pixel run
   `LWFC_ASSERT_IMPL(a_last_is_run, clock, reset, rsp_valid_ff && last_ff, kind_ff == lwfc_pkg::KIND_RUN)
   // mid-request the queue head must still hold the request
   `LWFC_ASSERT_IMPL(a_step_has_head, clock, reset, step_ff != lwfc_pkg::ST_BEGIN, !qstat.empty)

endmodule

// ===== sv/lcd_window_fill_command_generator_top.sv =====
// Channel   | Dir | Handshake     | Word
// ----------+-----+---------------+---------------------------------------------
// req_bus   | in  | valid/ready   | req_type, origin_x/y, rect_width/height, color
// rsp_bus   | out | valid/ready   | item_kind, byte_value, run_color/length, last
// csr_bus   | in  | valid/ready   | index (0 width, 1 height), 10-bit data
//
// A request emits 2 to 12 response words, one per cycle while rsp_bus is ready,
// so a request that changes both windows occupies the back-end sequencer for all
// 12 words; that sequencer is the throughput limit. The front takes one request
// per cycle while the 4-entry queue has room; dropped fills emit no words.
// Words pass through the stage-1 register, the queue and the output register.
// Synchronous reset: screen 240x320, window cache all ones, queue empty.
// rsp stalls back up through the queue to req_bus.ready; csr is always ready.

module lcd_window_fill_command_generator_top (
   input  logic       clock,
   input  logic       reset,
   lwfc_req_if.sink   req_bus,
   lwfc_rsp_if.source rsp_bus,
   lwfc_csr_if.sink   csr_bus
);

   lwfc_pkg::qstat_type qstat;
   lwfc_pkg::desc_type  push_desc;
   lwfc_pkg::desc_type  head;
   logic                push;
   logic                pop;

   // front end: clip, drop off-screen and zero-size fills, track the window cache
   lwfc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .csr    (csr_bus),
      .qstat  (qstat),
      .q_push (push),
      .q_desc (push_desc)
   );

   // decouples classification from word sequencing
   lwfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   // back end: one word per cycle into the registered output while rsp_bus is ready
   lwfc_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp_bus)
   );

endmodule

// ===== tb/tb.sv =====
module tb;

   // one request as presented on req_bus
   typedef struct packed {
      logic        kind;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] w;
      logic [15:0] h;
      logic [15:0] color;
   } fill_req_type;

   // one word as seen on rsp_bus
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_value;
      logic [15:0] run_color;
      logic [19:0] run_length;
      logic        last_item;
   } stream_word_type;

   // Keeps its own copy of the screen size and the window cache, expands each
   // accepted request into the command stream and checks response words in order.
   class fill_stream_checker;
      logic [9:0]      scr_w;
      logic [9:0]      scr_h;
      logic [15:0]     col_lo;
      logic [15:0]     col_hi;
      logic [15:0]     row_lo;
      logic [15:0]     row_hi;
      stream_word_type expected_stream[$];
      int unsigned     errors;
      int unsigned     requests;
      int unsigned     dropped;
      int unsigned     words;
      int unsigned     window_hits;

      function new();
         scr_w  = lwfc_pkg::SCREEN_WIDTH_RESET;
         scr_h  = lwfc_pkg::SCREEN_HEIGHT_RESET;
         col_lo = lwfc_pkg::CACHE_RESET;
         col_hi = lwfc_pkg::CACHE_RESET;
         row_lo = lwfc_pkg::CACHE_RESET;
         row_hi = lwfc_pkg::CACHE_RESET;
      endfunction

      task report(string msg);
         $display("[%0t] MISMATCH %s", $time, msg);
         errors++;
      endtask

      function int unsigned pending();
         return expected_stream.size();
      endfunction

      function void set_register(logic idx, logic [9:0] val);
         if (idx == lwfc_pkg::CSR_SCREEN_WIDTH) scr_w = val;
         else scr_h = val;
      endfunction

      function void push_word(logic [1:0] k, logic [7:0] b, logic [15:0] c,
                              logic [19:0] n, logic l);
         expected_stream.push_back('{k, b, c, n, l});
      endfunction

      // window command plus start and end, high byte first
      function void push_window(logic [7:0] cmd, logic [15:0] lo, logic [15:0] hi);
         push_word(lwfc_pkg::KIND_CMD, cmd, '0, '0, 1'b0);
         push_word(lwfc_pkg::KIND_DATA, lo[15:8], '0, '0, 1'b0);
         push_word(lwfc_pkg::KIND_DATA, lo[7:0], '0, '0, 1'b0);
         push_word(lwfc_pkg::KIND_DATA, hi[15:8], '0, '0, 1'b0);
         push_word(lwfc_pkg::KIND_DATA, hi[7:0], '0, '0, 1'b0);
      endfunction

      function void note_request(fill_req_type r);
         int unsigned w, h, x2, y2, run;
         requests++;
         if (r.kind == lwfc_pkg::REQ_FILL) begin
            if (r.x >= scr_w || r.y >= scr_h || r.w == 0 || r.h == 0) begin
               dropped++;
               return;
            end
            w = 32'(r.w);
            h = 32'(r.h);
            if (r.x + w - 1 >= scr_w) w = scr_w - r.x;
            if (r.y + h - 1 >= scr_h) h = scr_h - r.y;
            x2  = r.x + w - 1;
            y2  = r.y + h - 1;
            run = w * h;
         end else begin
            x2  = (r.x + 1) & 16'hFFFF;
            y2  = (r.y + 1) & 16'hFFFF;
            run = 1;
         end
         if (r.x != col_lo || x2[15:0] != col_hi) begin
            push_window(lwfc_pkg::CMD_COL_SET, r.x, x2[15:0]);
            col_lo = r.x;
            col_hi = x2[15:0];
         end else window_hits++;
         if (r.y != row_lo || y2[15:0] != row_hi) begin
            push_window(lwfc_pkg::CMD_ROW_SET, r.y, y2[15:0]);
            row_lo = r.y;
            row_hi = y2[15:0];
         end else window_hits++;
         push_word(lwfc_pkg::KIND_CMD, lwfc_pkg::CMD_MEM_WRITE, '0, '0, 1'b0);
         push_word(lwfc_pkg::KIND_RUN, '0, r.color, run[19:0], 1'b1);
      endfunction

      task compare_field(string field, int unsigned got, int unsigned want);
         if (got != want)
            report($sformatf("%s got %0h want %0h (word %0d)", field, got, want, words));
      endtask

      task check_word(stream_word_type got);
         stream_word_type want;
         words++;
         if (expected_stream.size() == 0) begin
            report($sformatf("unexpected word kind %0d byte %02h", got.kind, got.byte_value));
            return;
         end
         want = expected_stream.pop_front();
         compare_field("item_kind", got.kind, want.kind);
         compare_field("byte_value", got.byte_value, want.byte_value);
         compare_field("run_color", got.run_color, want.run_color);
         compare_field("run_length", got.run_length, want.run_length);
         compare_field("last_item", got.last_item, want.last_item);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic steady;            // high: neither side idles
   fill_req_type last_req;  // replayed with new color to hit the window cache

   fill_stream_checker sb;

   lwfc_req_if req_bus();
   lwfc_rsp_if rsp_bus();
   lwfc_csr_if csr_bus();

   lcd_window_fill_command_generator_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // receiver: ready low ~35% of cycles unless in the steady stretch
   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 35);
   end

   // every accepted response word goes straight to the checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_word('{rsp_bus.item_kind, rsp_bus.byte_value, rsp_bus.run_color,
                         rsp_bus.run_length, rsp_bus.last_item});
   end

   function automatic fill_req_type mk(logic k, logic [15:0] x, logic [15:0] y,
                                       logic [15:0] w, logic [15:0] h, logic [15:0] c);
      fill_req_type r;
      r.kind  = k;
      r.x     = x;
      r.y     = y;
      r.w     = w;
      r.h     = h;
      r.color = c;
      return r;
   endfunction

   // Mostly well-formed fills inside the current screen, plus pixels, replays of
   // the last geometry (cache hits) and some fully random noise.
   function automatic fill_req_type random_request();
      fill_req_type r;
      int unsigned  pick, sw, sh;
      sw = sb.scr_w;
      sh = sb.scr_h;
      pick = $urandom_range(99);
      r = mk(lwfc_pkg::REQ_FILL, 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), 16'($urandom));
      if (pick < 12) begin
         r.kind = 1'($urandom_range(1));
      end else if (pick < 27) begin
         r = last_req;
         r.color = 16'($urandom);
      end else if (pick < 45 || sw == 0 || sh == 0) begin
         r.kind = lwfc_pkg::REQ_PIXEL;
         if ($urandom_range(1)) begin
            r.x = 16'($urandom_range(3));
            r.y = 16'($urandom_range(3));
         end else if ($urandom_range(3) == 0) begin
            // near the top of the range: window end may wrap
            r.x = 16'hFFFF - 16'($urandom_range(1));
            r.y = 16'hFFFF - 16'($urandom_range(1));
         end
      end else begin
         r.x = 16'($urandom_range(sw - 1));
         r.y = 16'($urandom_range(sh - 1));
         case ($urandom_range(3))
            0: begin
               r.w = 16'($urandom_range(8));
               r.h = 16'($urandom_range(8));
            end
            1: begin
               r.w = 16'($urandom_range(sw));
               r.h = 16'($urandom_range(sh));
            end
            2: begin
               // reaches exactly to the screen edge
               r.w = 16'(sw - r.x);
               r.h = 16'(sh - r.y);
            end
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   // Present one request. Sender idles ~35% of cycles outside the steady stretch.
   // Within this task valid is only lowered while idling, so back-to-back requests keep it high.
   task automatic send_request(fill_req_type r);
      if (!steady)
         while ($urandom_range(99) < 35) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= r.kind;
      req_bus.origin_x    <= r.x;
      req_bus.origin_y    <= r.y;
      req_bus.rect_width  <= r.w;
      req_bus.rect_height <= r.h;
      req_bus.fill_color  <= r.color;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(r);
      last_req = r;
   endtask

   // hold off the sender until every expected word has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // register write; only called with the block idle
   task automatic write_csr(logic idx, logic [9:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.set_register(idx, val);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // drain, then allow for a dropped fill still in the front end
   task automatic settle_and_configure(logic [9:0] w, logic [9:0] h);
      wait_drained();
      repeat (8) @(posedge clock);
      write_csr(lwfc_pkg::CSR_SCREEN_WIDTH, w);
      write_csr(lwfc_pkg::CSR_SCREEN_HEIGHT, h);
   endtask

   // random phases: screen size and number of requests each
   logic [9:0]  phase_w[6];
   logic [9:0]  phase_h[6];
   int unsigned phase_n[6];

   initial begin
      sb = new();
      reset               = 1'b1;
      steady              = 1'b0;
      last_req            = '0;
      req_bus.valid       = 1'b0;
      req_bus.req_type    = lwfc_pkg::REQ_FILL;
      req_bus.origin_x    = '0;
      req_bus.origin_y    = '0;
      req_bus.rect_width  = '0;
      req_bus.rect_height = '0;
      req_bus.fill_color  = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = lwfc_pkg::CSR_SCREEN_WIDTH;
      csr_bus.data        = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // --- directed, reset screen 240x320 ---
      send_request(mk(lwfc_pkg::REQ_FILL, 0, 0, 10, 10, 16'h0000));   // both windows sent
      send_request(mk(lwfc_pkg::REQ_FILL, 0, 0, 10, 10, 16'hFFFF));   // both cached
      send_request(mk(lwfc_pkg::REQ_FILL, 240, 0, 5, 5, 16'h1111));   // x just off screen
      send_request(mk(lwfc_pkg::REQ_FILL, 0, 320, 5, 5, 16'h2222));   // y just off screen
      send_request(mk(lwfc_pkg::REQ_FILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF));
      send_request(mk(lwfc_pkg::REQ_FILL, 3, 4, 0, 7, 16'h3333));     // zero width
      send_request(mk(lwfc_pkg::REQ_FILL, 3, 4, 7, 0, 16'h4444));     // zero height
      send_request(mk(lwfc_pkg::REQ_FILL, 239, 319, 1, 1, 16'h5555)); // last on-screen pixel
      send_request(mk(lwfc_pkg::REQ_FILL, 200, 300, 16'hFFFF, 16'hFFFF,
                      16'h6666));                                      // clipped both
      send_request(mk(lwfc_pkg::REQ_FILL, 0, 0, 240, 320, 16'h7777)); // exact full screen
      send_request(mk(lwfc_pkg::REQ_FILL, 0, 0, 241, 321, 16'h8888)); // one over
      send_request(mk(lwfc_pkg::REQ_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'h9999));                                      // wrap
      send_request(mk(lwfc_pkg::REQ_PIXEL, 16'hFFFF, 16'hFFFF, 0, 0, 16'hAAAA)); // cached
      send_request(mk(lwfc_pkg::REQ_PIXEL, 5, 5, 0, 0, 16'h1234));
      send_request(mk(lwfc_pkg::REQ_PIXEL, 5, 9, 0, 0, 16'h5678));    // row only
      send_request(mk(lwfc_pkg::REQ_PIXEL, 9, 9, 0, 0, 16'h9ABC));    // column only
      send_request(mk(lwfc_pkg::REQ_FILL, 0, 0, 16'hFFFF, 1, 16'hA55A));
      send_request(mk(lwfc_pkg::REQ_FILL, 16'h00AA, 16'h0055, 16'h5555, 16'hAAAA,
                      16'h5AA5));
      send_request(mk(lwfc_pkg::REQ_PIXEL, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                      16'hF00F));

      // largest screen: longest possible run
      settle_and_configure(10'd1023, 10'd1023);
      send_request(mk(lwfc_pkg::REQ_FILL, 0, 0, 16'hFFFF, 16'hFFFF, 16'h0F0F));
      send_request(mk(lwfc_pkg::REQ_FILL, 1022, 1022, 2, 2, 16'hF0F0));
      send_request(mk(lwfc_pkg::REQ_FILL, 1023, 0, 1, 1, 16'h0001));

      // one-pixel screen
      settle_and_configure(10'd1, 10'd1);
      send_request(mk(lwfc_pkg::REQ_FILL, 0, 0, 5, 5, 16'h0002));
      send_request(mk(lwfc_pkg::REQ_FILL, 1, 0, 1, 1, 16'h0004));

      // zero width: every fill dropped, pixels still go out
      settle_and_configure(10'd0, 10'd1);
      send_request(mk(lwfc_pkg::REQ_FILL, 0, 0, 1, 1, 16'h0008));
      send_request(mk(lwfc_pkg::REQ_PIXEL, 3, 3, 0, 0, 16'h0010));

      // --- random phases ---
      phase_w = '{10'($urandom_range(1, 1023)), 10'd1023, 10'($urandom_range(1, 16)),
                  10'd0, 10'($urandom_range(1, 1023)), 10'($urandom_range(1, 64))};
      phase_h = '{10'($urandom_range(1, 1023)), 10'd1023, 10'($urandom_range(1, 16)),
                  10'($urandom_range(1, 1023)), 10'd0, 10'($urandom_range(1, 1023))};
      phase_n = '{80, 80, 70, 20, 20, 70};
      foreach (phase_n[p]) begin
         settle_and_configure(phase_w[p], phase_h[p]);
         steady <= (p == 1);   // long stretch with no idling on either side
         for (int i = 0; i < phase_n[p]; i++) begin
            if ((p == 0 && i == 40) || $urandom_range(39) == 0)
               wait_drained();
            send_request(random_request());
         end
      end
      steady <= 1'b0;
      req_bus.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d requests (%0d fills dropped), %0d words, %0d cached windows",
               sb.requests, sb.dropped, sb.words, sb.window_hits);
      $display("Screen sizes 0, 1 and 1023 plus random, stalls on both sides and none");
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #3000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
